// ----- rtl/frsm_pkg.sv -----
// Shared constants and types for the frame rate statistics monitor.
package frsm_pkg;

  localparam int TIME_W  = 32;
  localparam int FPS_W   = 16;
  localparam int WIN_W   = 16;
  localparam int SCALE_W = 14;
  localparam int PROD_W  = TIME_W + SCALE_W;
  localparam int QCNT_W  = 4;

  // Input mode codes.
  localparam logic MODE_FRAME   = 1'b0;
  localparam logic MODE_RESTART = 1'b1;

  // 1000 milliseconds per second scaled by 16 for the 12.4 result.
  localparam logic [SCALE_W-1:0] FPS_SCALE       = 14'd16000;
  localparam logic [FPS_W-1:0]   FPS_MAX         = 16'hFFFF;
  localparam logic [TIME_W-1:0]  FRAME_MS_INIT   = 32'd999999;
  localparam logic [FPS_W-1:0]   FLOOR_FPS_INIT  = 16'd15984;
  localparam logic [WIN_W-1:0]   WINDOW_MS_RESET = 16'd1000;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] num;
    logic [TIME_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [FPS_W-1:0] quot;
  } div_rsp_t;

endpackage

// ----- rtl/frsm_if.sv -----
// Valid/ready channel interfaces for input events, results and configuration.
interface frsm_in_if;
  import frsm_pkg::*;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [TIME_W-1:0] now_ms;
  modport source (output valid, mode, now_ms, input ready);
  modport sink   (input valid, mode, now_ms, output ready);
endinterface

interface frsm_out_if;
  import frsm_pkg::*;
  logic              valid;
  logic              ready;
  logic [FPS_W-1:0]  last_fps;
  logic [FPS_W-1:0]  avg_fps;
  logic [FPS_W-1:0]  best_fps;
  logic [FPS_W-1:0]  worst_fps;
  logic [TIME_W-1:0] best_frame_ms;
  logic [TIME_W-1:0] worst_frame_ms;
  logic              window_closed;
  modport source (output valid, last_fps, avg_fps, best_fps, worst_fps, best_frame_ms,
                  worst_frame_ms, window_closed, input ready);
  modport sink   (input valid, last_fps, avg_fps, best_fps, worst_fps, best_frame_ms,
                  worst_frame_ms, window_closed, output ready);
endinterface

interface frsm_cfg_if;
  import frsm_pkg::*;
  logic             valid;
  logic             ready;
  logic [WIN_W-1:0] window_ms;
  modport source (output valid, window_ms, input ready);
  modport sink   (input valid, window_ms, output ready);
endinterface

// ----- rtl/frame_rate_statistics_monitor_core.sv -----
// Path: a restart word goes straight to S_DONE; a frame word passes S_FT, S_MM and S_CHK,
// and one that closes the window also waits in S_DIV for the 16-step divider (cut short
// when the FPS saturates), then S_FPS and S_PK. S_DONE waits for the output register.
// One word is in flight at a time; in_ch.ready returns once the result is registered.
// Synchronous active-low reset restores all statistics and sets window_ms to 1000.
module frame_rate_statistics_monitor_core (
  input logic        clk,
  input logic        rst_n,
  frsm_in_if.sink    in_ch,
  frsm_out_if.source out_ch,
  frsm_cfg_if.sink   cfg_ch
);
  import frsm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FT   = 3'd1;
  localparam logic [2:0] S_MM   = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FPS  = 3'd5;
  localparam logic [2:0] S_PK   = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [WIN_W-1:0]  window_ms_r, window_ms_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [TIME_W-1:0] prev_r, prev_nxt;
  logic [TIME_W-1:0] wstart_r, wstart_nxt;
  logic [TIME_W-1:0] frames_r, frames_nxt;
  logic [TIME_W-1:0] ftime_r, ftime_nxt;
  logic [TIME_W-1:0] elapsed_r, elapsed_nxt;
  logic [TIME_W-1:0] short_r, short_nxt;
  logic [TIME_W-1:0] long_r, long_nxt;
  logic [FPS_W-1:0]  wfps_r, wfps_nxt;
  logic [FPS_W-1:0]  mean_r, mean_nxt;
  logic [FPS_W-1:0]  peak_r, peak_nxt;
  logic [FPS_W-1:0]  floor_r, floor_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic              closed_r, closed_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [FPS_W-1:0]  o_last_r, o_avg_r, o_best_r, o_worst_r;
  logic [TIME_W-1:0] o_bfm_r, o_wfm_r;
  logic              o_closed_r;
  logic              out_load;

  logic [FPS_W:0]    mean_sum;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  frsm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign div_req.start = (state_r == S_CHK) && (elapsed_r > {16'b0, window_ms_r});
  assign div_req.num   = prod_r;
  assign div_req.den   = elapsed_r;

  assign mean_sum = {1'b0, mean_r} + {1'b0, div_rsp.quot};
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt     = state_r;
    window_ms_nxt = window_ms_r;
    now_nxt       = now_r;
    prev_nxt      = prev_r;
    wstart_nxt    = wstart_r;
    frames_nxt    = frames_r;
    ftime_nxt     = ftime_r;
    elapsed_nxt   = elapsed_r;
    short_nxt     = short_r;
    long_nxt      = long_r;
    wfps_nxt      = wfps_r;
    mean_nxt      = mean_r;
    peak_nxt      = peak_r;
    floor_nxt     = floor_r;
    prod_nxt      = prod_r;
    closed_nxt    = closed_r;

    if (cfg_ch.valid) begin
      window_ms_nxt = cfg_ch.window_ms;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          now_nxt    = in_ch.now_ms;
          closed_nxt = 1'b0;
          if (in_ch.mode == MODE_RESTART) begin
            prev_nxt   = in_ch.now_ms;
            wstart_nxt = in_ch.now_ms;
            frames_nxt = '0;
            short_nxt  = FRAME_MS_INIT;
            long_nxt   = '0;
            wfps_nxt   = '0;
            mean_nxt   = '0;
            peak_nxt   = '0;
            floor_nxt  = FLOOR_FPS_INIT;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_FT;
          end
        end
      end
      S_FT: begin
        ftime_nxt  = now_r - prev_r;
        prev_nxt   = now_r;
        frames_nxt = frames_r + 1'b1;
        state_nxt  = S_MM;
      end
      S_MM: begin
        if (ftime_r < short_r) begin
          short_nxt = ftime_r;
        end
        if (ftime_r > long_r) begin
          long_nxt = ftime_r;
        end
        elapsed_nxt = now_r - wstart_r;
        prod_nxt    = {14'b0, frames_r} * {32'b0, FPS_SCALE};
        state_nxt   = S_CHK;
      end
      S_CHK: begin
        state_nxt = div_req.start ? S_DIV : S_DONE;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          wfps_nxt  = div_rsp.quot;
          mean_nxt  = (mean_r == '0) ? div_rsp.quot : mean_sum[FPS_W:1];
          state_nxt = S_FPS;
        end
      end
      S_FPS: begin
        if (wfps_r > peak_r) begin
          peak_nxt = wfps_r;
        end
        if (wfps_r < floor_r) begin
          floor_nxt = wfps_r;
        end
        state_nxt = S_PK;
      end
      S_PK: begin
        wstart_nxt = now_r;
        frames_nxt = '0;
        closed_nxt = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      window_ms_r <= WINDOW_MS_RESET;
      prev_r      <= '0;
      wstart_r    <= '0;
      frames_r    <= '0;
      short_r     <= FRAME_MS_INIT;
      long_r      <= '0;
      wfps_r      <= '0;
      mean_r      <= '0;
      peak_r      <= '0;
      floor_r     <= FLOOR_FPS_INIT;
      closed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      window_ms_r <= window_ms_nxt;
      prev_r      <= prev_nxt;
      wstart_r    <= wstart_nxt;
      frames_r    <= frames_nxt;
      short_r     <= short_nxt;
      long_r      <= long_nxt;
      wfps_r      <= wfps_nxt;
      mean_r      <= mean_nxt;
      peak_r      <= peak_nxt;
      floor_r     <= floor_nxt;
      closed_r    <= closed_nxt;
      out_valid_r <= out_valid_nxt;
    end
    now_r     <= now_nxt;
    ftime_r   <= ftime_nxt;
    elapsed_r <= elapsed_nxt;
    prod_r    <= prod_nxt;
  end

  // The result word is held here so the next event can start while it waits.
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_last_r   <= wfps_r;
      o_avg_r    <= mean_r;
      o_best_r   <= peak_r;
      o_worst_r  <= floor_r;
      o_bfm_r    <= short_r;
      o_wfm_r    <= long_r;
      o_closed_r <= closed_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.last_fps       = o_last_r;
  assign out_ch.avg_fps        = o_avg_r;
  assign out_ch.best_fps       = o_best_r;
  assign out_ch.worst_fps      = o_worst_r;
  assign out_ch.best_frame_ms  = o_bfm_r;
  assign out_ch.worst_frame_ms = o_wfm_r;
  assign out_ch.window_closed  = o_closed_r;

endmodule

// ----- rtl/frsm_div.sv -----
// Radix-2 restoring divider with saturation to a 16-bit quotient.
module frsm_div (
  input  logic               clk,
  input  logic               rst_n,
  input  frsm_pkg::div_req_t req,
  output frsm_pkg::div_rsp_t rsp
);
  import frsm_pkg::*;

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_SAT  = 2'd1;
  localparam logic [1:0] D_STEP = 2'd2;

  logic [1:0]              dst_r, dst_nxt;
  logic [QCNT_W-1:0]       cnt_r, cnt_nxt;
  logic                    done_r, done_nxt;
  logic [TIME_W-1:0]       den_r, den_nxt;
  logic [TIME_W-1:0]       rem_r, rem_nxt;
  logic [PROD_W-FPS_W-1:0] hi_r, hi_nxt;
  logic [FPS_W-1:0]        lo_r, lo_nxt;
  logic [FPS_W-1:0]        quot_r, quot_nxt;

  logic [TIME_W:0]   unit_a;
  logic [TIME_W+1:0] diff;
  logic              ge;

  // The one compare/subtract unit: first the overflow test on the upper
  // bits, then one quotient bit per cycle.
  assign unit_a = (dst_r == D_SAT) ? {3'b0, hi_r} : {rem_r, lo_r[FPS_W-1]};
  assign diff   = {1'b0, unit_a} - {2'b0, den_r};
  assign ge     = ~diff[TIME_W+1];

  always_comb begin
    dst_nxt  = dst_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    quot_nxt = quot_r;
    case (dst_r)
      D_IDLE: begin
        if (req.start) begin
          hi_nxt  = req.num[PROD_W-1:FPS_W];
          lo_nxt  = req.num[FPS_W-1:0];
          den_nxt = req.den;
          dst_nxt = D_SAT;
        end
      end
      D_SAT: begin
        if (ge) begin
          quot_nxt = FPS_MAX;
          done_nxt = 1'b1;
          dst_nxt  = D_IDLE;
        end else begin
          rem_nxt = {2'b0, hi_r};
          cnt_nxt = '0;
          dst_nxt = D_STEP;
        end
      end
      D_STEP: begin
        rem_nxt  = ge ? diff[TIME_W-1:0] : unit_a[TIME_W-1:0];
        quot_nxt = {quot_r[FPS_W-2:0], ge};
        lo_nxt   = {lo_r[FPS_W-2:0], 1'b0};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == QCNT_W'(FPS_W - 1)) begin
          done_nxt = 1'b1;
          dst_nxt  = D_IDLE;
        end
      end
      default: begin
        dst_nxt = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dst_r  <= D_IDLE;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      dst_r  <= dst_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    hi_r   <= hi_nxt;
    lo_r   <= lo_nxt;
    quot_r <= quot_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

// ----- rtl/frsm_checker.sv -----
// Port-level assertions for the frame rate statistics monitor, bound to the top level.
module frsm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [frsm_pkg::FPS_W-1:0]  last_fps,
  input logic [frsm_pkg::FPS_W-1:0]  best_fps,
  input logic [frsm_pkg::FPS_W-1:0]  worst_fps,
  input logic [frsm_pkg::TIME_W-1:0] best_frame_ms,
  input logic [frsm_pkg::TIME_W-1:0] worst_frame_ms,
  input logic                        window_closed
);
  import frsm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(last_fps) && $stable(best_frame_ms))
    else $error("result word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while one is in progress");

  a_frame_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (worst_frame_ms != '0) |-> best_frame_ms <= worst_frame_ms)
    else $error("shortest frame exceeds longest frame");

  a_fps_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && window_closed |-> (best_fps >= last_fps) && (worst_fps <= last_fps))
    else $error("best or worst FPS not updated by closed window");

endmodule

bind frame_rate_statistics_monitor_core frsm_checker u_frsm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .last_fps       (out_ch.last_fps),
  .best_fps       (out_ch.best_fps),
  .worst_fps      (out_ch.worst_fps),
  .best_frame_ms  (out_ch.best_frame_ms),
  .worst_frame_ms (out_ch.worst_frame_ms),
  .window_closed  (out_ch.window_closed)
);
